FILE: sv/atd_pkg.sv
// ----------------------------------------------------------------------------
// atd_pkg
// Types, register codes and constants of the twist-to-drive kinematics block.
// ----------------------------------------------------------------------------
package atd_pkg;

  localparam int RAD_FRAC     = 12;  // radius fraction bits
  localparam int ANG_FRAC     = 16;  // angle fraction bits
  localparam int DUTY_FRAC    = 8;   // servo gain fraction bits
  localparam int CORDIC_STEPS = 16;
  localparam int IN_W         = 16;
  localparam int DIV1_BITS    = 28;  // radius quotient bits
  localparam int MAG_W        = 28;  // radius magnitude
  localparam int XY_W         = 48;  // CORDIC x and y
  localparam int ANG_W        = 18;  // signed CORDIC angle accumulator
  localparam int ANGP_W       = 17;  // non-negative angle
  localparam int XGM_W        = 25;  // |forward speed| * speed_gain
  localparam int FAC_W        = 29;  // |2R -/+ track|
  localparam int DEN2_W       = 29;  // 2|R|
  localparam int PROD_W       = XGM_W + FAC_W;
  localparam int SMAG_W       = 17;  // straight speed magnitude
  localparam int DPROD_W      = 35;  // servo_gain * angle
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RADIUS   = 3'd0,
    REG_AXLE_BASE    = 3'd1,
    REG_WHEEL_TRACK  = 3'd2,
    REG_SPEED_GAIN   = 3'd3,
    REG_SERVO_GAIN   = 3'd4,
    REG_SERVO_OFFSET = 3'd5,
    REG_SPEED_LIMIT  = 3'd6
  } cfg_reg_e;

  localparam logic [12:0] RST_MIN_RADIUS   = 13'd614;
  localparam logic [12:0] RST_AXLE_BASE    = 13'd635;
  localparam logic [12:0] RST_WHEEL_TRACK  = 13'd492;
  localparam logic [9:0]  RST_SPEED_GAIN   = 10'd189;
  localparam logic [17:0] RST_SERVO_GAIN   = 18'd181957;
  localparam logic [15:0] RST_SERVO_OFFSET = 16'd12888;
  localparam logic [14:0] RST_SPEED_LIMIT  = 15'd100;

  // atan(2^-i) in Q.16 radians
  function automatic logic [ANG_W-1:0] atan_lut(input int unsigned i);
    logic [ANG_W-1:0] v;
    case (i)
      0:       v = 18'd51472;
      1:       v = 18'd30386;
      2:       v = 18'd16055;
      3:       v = 18'd8150;
      4:       v = 18'd4091;
      5:       v = 18'd2047;
      6:       v = 18'd1024;
      7:       v = 18'd512;
      8:       v = 18'd256;
      9:       v = 18'd128;
      10:      v = 18'd64;
      11:      v = 18'd32;
      12:      v = 18'd16;
      13:      v = 18'd8;
      14:      v = 18'd4;
      15:      v = 18'd2;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

  // item attributes carried along the front half
  typedef struct packed {
    logic             sx;   // forward speed negative
    logic             nz;   // both inputs nonzero
    logic             neg;  // turn radius negative
    logic [XGM_W-1:0] xgm;  // |forward speed| * speed_gain
  } side_t;

  typedef struct packed {
    logic [DIV1_BITS-1:0] rem;
    logic [IN_W-1:0]      den;
    logic [DIV1_BITS-1:0] quo;
    side_t                side;
  } div1_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;
    logic [MAG_W-1:0]        mag;
    logic                    ab0;  // axle base zero
    side_t                   side;
  } cor_t;

endpackage

FILE: sv/ackermann_twist_to_drive_top.sv
// ----------------------------------------------------------------------------
// ackermann_twist_to_drive_top
// Ackermann inverse kinematics: forward speed and yaw rate to left and right
// wheel speed commands and a steering servo duty, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | ports                                       | handshake
//  ---------+---------------------------------------------+------------------
//  command  | fwd_vel_i, angular_z_i                      | start_i, busy_o
//  result   | left_cmd_o, right_cmd_o, steer_duty_o       | done_o strobe
//  config   | cfg_idx_i, cfg_wdata_i                      | cfg_we_i
//
//  One beat enters per cycle; busy_o stays low. A result strobes on done_o
//  after its command has passed the radius divider (28 stages), the 16-stage
//  CORDIC and the wheel divider (INPUT_FRAC_BITS+16 stages). Reset clears valid
//  bits and loads register defaults. The result side has no stall; every beat
//  is shown for one cycle only.
// ----------------------------------------------------------------------------
module ackermann_twist_to_drive_top #(
  parameter int INPUT_FRAC_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [15:0]                   fwd_vel_i,
  input  logic signed [15:0]                   angular_z_i,
  output logic                                 done_o,
  output logic signed [15:0]                   left_cmd_o,
  output logic signed [15:0]                   right_cmd_o,
  output logic signed [15:0]                   steer_duty_o,
  input  logic                                 cfg_we_i,
  input  logic [atd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [atd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam int QW  = 16 + INPUT_FRAC_BITS;  // wheel quotient bits
  localparam int CW  = ((atd_pkg::PROD_W > atd_pkg::DEN2_W + QW) ?
                        atd_pkg::PROD_W : atd_pkg::DEN2_W + QW) + 1;
  localparam int LAT = 7 + atd_pkg::DIV1_BITS + atd_pkg::CORDIC_STEPS + QW;

  typedef struct packed {
    logic [atd_pkg::PROD_W-1:0] rem_l;
    logic [atd_pkg::PROD_W-1:0] rem_r;
    logic [atd_pkg::DEN2_W-1:0] den;
    logic [QW-1:0]              quo_l;
    logic [QW-1:0]              quo_r;
    logic                       ovf_l;
    logic                       ovf_r;
    logic                       neg_l;
    logic                       neg_r;
    logic                       straight;
    logic                       sx;
    logic [atd_pkg::SMAG_W-1:0] smag;
    logic signed [15:0]         duty;
  } div2_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [12:0] min_radius_q, axle_base_q, wheel_track_q;
  logic [9:0]  speed_gain_q;
  logic [17:0] servo_gain_q;
  logic [15:0] servo_offset_q;
  logic [14:0] speed_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_radius_q   <= atd_pkg::RST_MIN_RADIUS;
      axle_base_q    <= atd_pkg::RST_AXLE_BASE;
      wheel_track_q  <= atd_pkg::RST_WHEEL_TRACK;
      speed_gain_q   <= atd_pkg::RST_SPEED_GAIN;
      servo_gain_q   <= atd_pkg::RST_SERVO_GAIN;
      servo_offset_q <= atd_pkg::RST_SERVO_OFFSET;
      speed_limit_q  <= atd_pkg::RST_SPEED_LIMIT;
    end else if (cfg_we_i) begin
      case (atd_pkg::cfg_reg_e'(cfg_idx_i))
        atd_pkg::REG_MIN_RADIUS:   min_radius_q   <= cfg_wdata_i[12:0];
        atd_pkg::REG_AXLE_BASE:    axle_base_q    <= cfg_wdata_i[12:0];
        atd_pkg::REG_WHEEL_TRACK:  wheel_track_q  <= cfg_wdata_i[12:0];
        atd_pkg::REG_SPEED_GAIN:   speed_gain_q   <= cfg_wdata_i[9:0];
        atd_pkg::REG_SERVO_GAIN:   servo_gain_q   <= cfg_wdata_i;
        atd_pkg::REG_SERVO_OFFSET: servo_offset_q <= cfg_wdata_i[15:0];
        atd_pkg::REG_SPEED_LIMIT:  speed_limit_q  <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // --------------------------------------------------------------------------
  // Input stage and operand prep
  // --------------------------------------------------------------------------
  logic                in_v_q;
  logic signed [15:0]  x_q, z_q;
  logic [15:0]         ax, az;
  logic [25:0]         xg_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_v_q <= 1'b0;
    else         in_v_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= fwd_vel_i;
      z_q <= angular_z_i;
    end
  end

  always_comb begin
    ax      = x_q[15] ? 16'(-x_q) : 16'(x_q);
    az      = z_q[15] ? 16'(-z_q) : 16'(z_q);
    xg_full = 26'(ax) * 26'(speed_gain_q);
  end

  // --------------------------------------------------------------------------
  // Radius divider: |x| << 12 / |z|, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic [atd_pkg::DIV1_BITS:0] d1_v_q;
  atd_pkg::div1_t              d1_q [atd_pkg::DIV1_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d1_v_q <= '0;
    else         d1_v_q <= {d1_v_q[atd_pkg::DIV1_BITS-1:0], in_v_q};
  end

  always_ff @(posedge clk_i) begin
    d1_q[0].rem       <= atd_pkg::DIV1_BITS'(ax) << atd_pkg::RAD_FRAC;
    d1_q[0].den       <= az;
    d1_q[0].quo       <= '0;
    d1_q[0].side.sx   <= x_q[15];
    d1_q[0].side.nz   <= (x_q != 16'sd0) && (z_q != 16'sd0);
    d1_q[0].side.neg  <= x_q[15] ^ z_q[15];
    d1_q[0].side.xgm  <= xg_full[atd_pkg::XGM_W-1:0];
  end

  for (genvar j = 0; j < atd_pkg::DIV1_BITS; j++) begin : g_div1
    localparam int B = atd_pkg::DIV1_BITS - 1 - j;
    logic [atd_pkg::DIV1_BITS+15:0] sh;
    logic                           ge;
    atd_pkg::div1_t                 nxt;
    always_comb begin
      sh  = (atd_pkg::DIV1_BITS + 16)'(d1_q[j].den) << B;
      ge  = (atd_pkg::DIV1_BITS + 16)'(d1_q[j].rem) >= sh;
      nxt = d1_q[j];
      if (ge) begin
        nxt.rem    = d1_q[j].rem - sh[atd_pkg::DIV1_BITS-1:0];
        nxt.quo[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      d1_q[j+1] <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Radius floor and CORDIC seed
  // --------------------------------------------------------------------------
  logic [atd_pkg::MAG_W-1:0] mag_clamp;
  logic                      c_v0_q;

  always_comb begin
    mag_clamp = d1_q[atd_pkg::DIV1_BITS].quo;
    if (mag_clamp < atd_pkg::MAG_W'(min_radius_q)) mag_clamp = atd_pkg::MAG_W'(min_radius_q);
    if (mag_clamp == '0) mag_clamp = atd_pkg::MAG_W'(1);
  end

  logic [atd_pkg::CORDIC_STEPS:0] c_v_q;
  atd_pkg::cor_t                  c_q [atd_pkg::CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q <= '0;
    else         c_v_q <= {c_v_q[atd_pkg::CORDIC_STEPS-1:0], d1_v_q[atd_pkg::DIV1_BITS]};
  end
  assign c_v0_q = c_v_q[0];

  always_ff @(posedge clk_i) begin
    c_q[0].x    <= atd_pkg::XY_W'(mag_clamp) << atd_pkg::ANG_FRAC;
    c_q[0].y    <= atd_pkg::XY_W'(axle_base_q) << atd_pkg::ANG_FRAC;
    c_q[0].ang  <= '0;
    c_q[0].mag  <= mag_clamp;
    c_q[0].ab0  <= (axle_base_q == 13'd0);
    c_q[0].side <= d1_q[atd_pkg::DIV1_BITS].side;
  end

  // rotate toward y = 0, one micro-rotation per stage
  for (genvar k = 0; k < atd_pkg::CORDIC_STEPS; k++) begin : g_cordic
    logic signed [atd_pkg::XY_W-1:0] dx, dy;
    atd_pkg::cor_t                   nxt;
    always_comb begin
      dx  = c_q[k].y >>> k;
      dy  = c_q[k].x >>> k;
      nxt = c_q[k];
      if (!c_q[k].y[atd_pkg::XY_W-1]) begin
        nxt.x   = c_q[k].x + dx;
        nxt.y   = c_q[k].y - dy;
        nxt.ang = c_q[k].ang + $signed(atd_pkg::atan_lut(k));
      end else begin
        nxt.x   = c_q[k].x - dx;
        nxt.y   = c_q[k].y + dy;
        nxt.ang = c_q[k].ang - $signed(atd_pkg::atan_lut(k));
      end
    end
    always_ff @(posedge clk_i) begin
      c_q[k+1] <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Angle, wheel factors and servo product
  // --------------------------------------------------------------------------
  atd_pkg::cor_t                 cf;
  logic [atd_pkg::ANGP_W-1:0]    ang_pos;
  logic [atd_pkg::DEN2_W-1:0]    two_mag;
  logic                          u_neg;
  logic [atd_pkg::FAC_W-1:0]     u_abs, v_sum;

  assign cf = c_q[atd_pkg::CORDIC_STEPS];

  always_comb begin
    ang_pos = cf.ang[atd_pkg::ANG_W-1] ? '0 : cf.ang[atd_pkg::ANGP_W-1:0];
    two_mag = {cf.mag, 1'b0};
    u_neg   = two_mag < atd_pkg::DEN2_W'(wheel_track_q);
    u_abs   = u_neg ? atd_pkg::FAC_W'(atd_pkg::DEN2_W'(wheel_track_q) - two_mag)
                    : atd_pkg::FAC_W'(two_mag - atd_pkg::DEN2_W'(wheel_track_q));
    v_sum   = atd_pkg::FAC_W'(two_mag + atd_pkg::DEN2_W'(wheel_track_q));
  end

  logic                         p3_v_q;
  logic [atd_pkg::FAC_W-1:0]    p3_fac_l_q, p3_fac_r_q;
  logic                         p3_neg_l_q, p3_neg_r_q;
  logic [atd_pkg::DEN2_W-1:0]   p3_den_q;
  logic [atd_pkg::DPROD_W-1:0]  p3_dprod_q;
  logic                         p3_straight_q, p3_neg_q;
  atd_pkg::side_t               p3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p3_v_q <= 1'b0;
    else         p3_v_q <= c_v_q[atd_pkg::CORDIC_STEPS];
  end

  always_ff @(posedge clk_i) begin
    // for a right turn (negative radius) the two factors swap sides
    p3_fac_l_q    <= cf.side.neg ? v_sum : u_abs;
    p3_fac_r_q    <= cf.side.neg ? u_abs : v_sum;
    p3_neg_l_q    <= cf.side.sx ^ (!cf.side.neg && u_neg);
    p3_neg_r_q    <= cf.side.sx ^ (cf.side.neg && u_neg);
    p3_den_q      <= two_mag;
    p3_dprod_q    <= atd_pkg::DPROD_W'(servo_gain_q) * atd_pkg::DPROD_W'(ang_pos);
    p3_straight_q <= !cf.side.nz || cf.ab0 || (ang_pos == '0);
    p3_neg_q      <= cf.side.neg;
    p3_side_q     <= cf.side;
  end

  // --------------------------------------------------------------------------
  // Wheel numerators and servo duty
  // --------------------------------------------------------------------------
  logic [atd_pkg::DPROD_W:0] duty_sum;
  logic [15:0]               duty_mag;

  always_comb begin
    duty_sum = (atd_pkg::DPROD_W+1)'(p3_dprod_q) +
               ((atd_pkg::DPROD_W+1)'(servo_offset_q) << atd_pkg::ANG_FRAC);
    duty_mag = 16'(duty_sum >> (atd_pkg::ANG_FRAC + atd_pkg::DUTY_FRAC));
  end

  logic                         p4_v_q;
  logic [atd_pkg::PROD_W-1:0]   p4_prod_l_q, p4_prod_r_q;
  logic [atd_pkg::DEN2_W-1:0]   p4_den_q;
  logic                         p4_neg_l_q, p4_neg_r_q, p4_straight_q, p4_sx_q;
  logic [atd_pkg::SMAG_W-1:0]   p4_smag_q;
  logic signed [15:0]           p4_duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p4_v_q <= 1'b0;
    else         p4_v_q <= p3_v_q;
  end

  always_ff @(posedge clk_i) begin
    p4_prod_l_q   <= atd_pkg::PROD_W'(p3_side_q.xgm) * atd_pkg::PROD_W'(p3_fac_l_q);
    p4_prod_r_q   <= atd_pkg::PROD_W'(p3_side_q.xgm) * atd_pkg::PROD_W'(p3_fac_r_q);
    p4_den_q      <= p3_den_q;
    p4_neg_l_q    <= p3_neg_l_q;
    p4_neg_r_q    <= p3_neg_r_q;
    p4_straight_q <= p3_straight_q;
    p4_sx_q       <= p3_side_q.sx;
    p4_smag_q     <= atd_pkg::SMAG_W'(p3_side_q.xgm >> INPUT_FRAC_BITS);
    p4_duty_q     <= p3_neg_q ? -$signed(duty_mag) : $signed(duty_mag);
  end

  // --------------------------------------------------------------------------
  // Wheel divider: numerator / 2|R|, saturating quotient of QW bits
  // --------------------------------------------------------------------------
  logic [QW:0] d2_v_q;
  div2_t       d2_q [QW+1];
  logic [CW-1:0] den_top;

  assign den_top = CW'(p4_den_q) << QW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d2_v_q <= '0;
    else         d2_v_q <= {d2_v_q[QW-1:0], p4_v_q};
  end

  always_ff @(posedge clk_i) begin
    d2_q[0].rem_l    <= p4_prod_l_q;
    d2_q[0].rem_r    <= p4_prod_r_q;
    d2_q[0].den      <= p4_den_q;
    d2_q[0].quo_l    <= '0;
    d2_q[0].quo_r    <= '0;
    d2_q[0].ovf_l    <= CW'(p4_prod_l_q) >= den_top;
    d2_q[0].ovf_r    <= CW'(p4_prod_r_q) >= den_top;
    d2_q[0].neg_l    <= p4_neg_l_q;
    d2_q[0].neg_r    <= p4_neg_r_q;
    d2_q[0].straight <= p4_straight_q;
    d2_q[0].sx       <= p4_sx_q;
    d2_q[0].smag     <= p4_smag_q;
    d2_q[0].duty     <= p4_duty_q;
  end

  for (genvar j = 0; j < QW; j++) begin : g_div2
    localparam int B = QW - 1 - j;
    logic [CW-1:0] sh;
    logic          ge_l, ge_r;
    div2_t         nxt;
    always_comb begin
      sh   = CW'(d2_q[j].den) << B;
      ge_l = CW'(d2_q[j].rem_l) >= sh;
      ge_r = CW'(d2_q[j].rem_r) >= sh;
      nxt  = d2_q[j];
      if (ge_l) begin
        nxt.rem_l    = d2_q[j].rem_l - sh[atd_pkg::PROD_W-1:0];
        nxt.quo_l[B] = 1'b1;
      end
      if (ge_r) begin
        nxt.rem_r    = d2_q[j].rem_r - sh[atd_pkg::PROD_W-1:0];
        nxt.quo_r[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      d2_q[j+1] <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output: drop fraction, clamp to the speed limit, apply sign
  // --------------------------------------------------------------------------
  div2_t                      df;
  logic [atd_pkg::SMAG_W-1:0] m_l, m_r;
  logic [14:0]                c_l, c_r;
  logic                       s_l, s_r;

  assign df = d2_q[QW];

  always_comb begin
    m_l = df.straight ? df.smag
        : (df.ovf_l ? '1 : atd_pkg::SMAG_W'(df.quo_l[QW-1:INPUT_FRAC_BITS]));
    m_r = df.straight ? df.smag
        : (df.ovf_r ? '1 : atd_pkg::SMAG_W'(df.quo_r[QW-1:INPUT_FRAC_BITS]));
    c_l = (m_l > atd_pkg::SMAG_W'(speed_limit_q)) ? speed_limit_q : m_l[14:0];
    c_r = (m_r > atd_pkg::SMAG_W'(speed_limit_q)) ? speed_limit_q : m_r[14:0];
    s_l = df.straight ? df.sx : df.neg_l;
    s_r = df.straight ? df.sx : df.neg_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= d2_v_q[QW];
  end

  always_ff @(posedge clk_i) begin
    left_cmd_o   <= s_l ? -$signed({1'b0, c_l}) : $signed({1'b0, c_l});
    right_cmd_o  <= s_r ? -$signed({1'b0, c_r}) : $signed({1'b0, c_r});
    steer_duty_o <= df.straight ? 16'sd0 : df.duty;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_done_follows_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result beat without a command");

  a_cmd_gets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("command beat lost in pipeline");

  a_left_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (left_cmd_o <= $signed({1'b0, speed_limit_q}) &&
                left_cmd_o >= -$signed({1'b0, speed_limit_q})))
    else $error("left speed outside limit");

  a_seed_valid_tracks_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_v0_q == $past(d1_v_q[atd_pkg::DIV1_BITS]))
    else $error("CORDIC seed valid out of step with divider");

endmodule

FILE: tb/ackermann_twist_to_drive_top_tb.sv
// ----------------------------------------------------------------------------
// ackermann_twist_to_drive_top_tb
// Self-checking bench: drives twist commands in random bursts, predicts the
// wheel speeds and servo duty of each command, and checks every done_o beat
// in order over several register settings.
// ----------------------------------------------------------------------------
module ackermann_twist_to_drive_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] lx;
    logic signed [15:0] az;
  } twist_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [15:0] duty;
  } drive_t;

  logic clk_i, rst_ni, start_i, busy_o, done_o, cfg_we_i;
  logic signed [15:0] fwd_vel_i, angular_z_i;
  logic signed [15:0] left_cmd_o, right_cmd_o, steer_duty_o;
  logic [atd_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [atd_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  twist_t twist_q[$];
  drive_t drive_q[$];
  int     n_err = 0;

  longint min_radius, axle_base, wheel_track, speed_gain, servo_gain, servo_offset,
          speed_limit;

  ackermann_twist_to_drive_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  function automatic logic signed [15:0] wheel_clamp(input longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    if (v > speed_limit) v = speed_limit;
    if (v < -speed_limit) v = -speed_limit;
    return 16'(v);
  endfunction

  function automatic longint steer_angle(input longint b, input longint r);
    longint x, y, ang, dx, dy;
    x = r * 65536;
    y = b * 65536;
    ang = 0;
    for (int i = 0; i < atd_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; ang += longint'(atd_pkg::atan_lut(i));
      end else begin
        x -= dx; y += dy; ang -= longint'(atd_pkg::atan_lut(i));
      end
    end
    return (ang < 0) ? 0 : ang;
  endfunction

  function automatic drive_t predict_drive(input twist_t t);
    drive_t d;
    longint x, z, q, mag, r, ang, s, den, ls, rs, duty;
    logic   neg;
    x = t.lx;
    z = t.az;
    ang = 0;
    r = 0;
    neg = 1'b0;
    if (x != 0 && z != 0) begin
      q = (x * 4096) / z;
      mag = (q < 0) ? -q : q;
      neg = (x < 0) != (z < 0);
      if (mag < min_radius) mag = min_radius;
      if (mag < 1) mag = 1;
      r = neg ? -mag : mag;
      if (axle_base != 0) ang = steer_angle(axle_base, mag);
    end
    if (ang == 0) begin
      s = (x * speed_gain) / 4096;
      d.left = wheel_clamp(s);
      d.right = wheel_clamp(s);
      d.duty = '0;
    end else begin
      den = 2 * r * 4096;
      ls = (x * speed_gain * (2 * r - wheel_track)) / den;
      rs = (x * speed_gain * (2 * r + wheel_track)) / den;
      duty = (servo_gain * ang + (servo_offset << 16)) >> 24;
      if (neg) duty = -duty;
      if (duty > 32767) duty = 32767;
      if (duty < -32768) duty = -32768;
      d.left = wheel_clamp(ls);
      d.right = wheel_clamp(rs);
      d.duty = 16'(duty);
    end
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [15:0] got,
                                 input logic signed [15:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    n_err++;
  endtask

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    twist_t t;
    logic   hold;
    if (!rst_ni) begin
      start_i <= 1'b0;
      fwd_vel_i <= '0;
      angular_z_i <= '0;
    end else begin
      hold = start_i && busy_o;
      if (start_i && !busy_o) begin
        t.lx = fwd_vel_i;
        t.az = angular_z_i;
        drive_q.push_back(predict_drive(t));
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (twist_q.size() > 0) begin
          t = twist_q.pop_front();
          fwd_vel_i <= t.lx;
          angular_z_i <= t.az;
          start_i <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 60);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    drive_t w;
    if (rst_ni && done_o) begin
      if (drive_q.size() == 0) begin
        $display("unexpected result beat");
        n_err++;
      end else begin
        w = drive_q.pop_front();
        if (left_cmd_o !== w.left) report_mismatch("left wheel", left_cmd_o, w.left);
        if (right_cmd_o !== w.right)
          report_mismatch("right wheel", right_cmd_o, w.right);
        if (steer_duty_o !== w.duty) report_mismatch("steer duty", steer_duty_o, w.duty);
      end
    end
  end

  task automatic write_regs(input longint v[7]);
    for (int i = 0; i < 7; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= atd_pkg::CFG_IDX_W'(i);
      cfg_wdata_i <= atd_pkg::CFG_DATA_W'(v[i]);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    min_radius = v[atd_pkg::REG_MIN_RADIUS] & 13'h1fff;
    axle_base = v[atd_pkg::REG_AXLE_BASE] & 13'h1fff;
    wheel_track = v[atd_pkg::REG_WHEEL_TRACK] & 13'h1fff;
    speed_gain = v[atd_pkg::REG_SPEED_GAIN] & 10'h3ff;
    servo_gain = v[atd_pkg::REG_SERVO_GAIN] & 18'h3ffff;
    servo_offset = v[atd_pkg::REG_SERVO_OFFSET] & 16'hffff;
    speed_limit = v[atd_pkg::REG_SPEED_LIMIT] & 15'h7fff;
  endtask

  task automatic wait_drained();
    while (twist_q.size() > 0 || start_i || drive_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic add_twist(input int lx, input int az);
    twist_t t;
    t.lx = 16'(lx);
    t.az = 16'(az);
    twist_q.push_back(t);
  endtask

  // half turning commands at moderate rates; the rest full-range noise, near-zero yaw or near-zero speed
  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: add_twist($urandom, $urandom);
        1: add_twist($urandom, $urandom_range(0, 1) ? 0 : $urandom_range(0, 3) - 1);
        2: add_twist($urandom_range(0, 15) - 8, $urandom);
        default: add_twist($urandom_range(0, 16000) - 8000, $urandom_range(0, 16000) - 8000);
      endcase
    end
  endtask

  initial begin
    longint v[7];
    rst_ni = 1'b0;
    start_i = 1'b0;
    fwd_vel_i = '0;
    angular_z_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    min_radius = atd_pkg::RST_MIN_RADIUS;
    axle_base = atd_pkg::RST_AXLE_BASE;
    wheel_track = atd_pkg::RST_WHEEL_TRACK;
    speed_gain = atd_pkg::RST_SPEED_GAIN;
    servo_gain = atd_pkg::RST_SERVO_GAIN;
    servo_offset = atd_pkg::RST_SERVO_OFFSET;
    speed_limit = atd_pkg::RST_SPEED_LIMIT;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: zeros, extremes, radius truncating to zero
    add_twist(0, 0);
    add_twist(32767, 0);
    add_twist(0, -32768);
    add_twist(-32768, -32768);
    add_twist(32767, 1);
    add_twist(1, 32767);
    add_twist(1, -32767);
    add_twist(-32768, 32767);
    add_twist(4096, 4096);
    add_twist(-4096, 4096);
    add_twist(-1, -1);
    add_twist(32767, -32768);
    add_random(250);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: v = '{8191, 8191, 8191, 1023, 262143, 65535, 32767};
        1: v = '{0, 0, 0, 0, 0, 0, 0};
        2: v = '{0, 4096, 8191, 1023, 262143, 0, 32767};
        default: begin
          foreach (v[k]) v[k] = $urandom;
          v[atd_pkg::REG_MIN_RADIUS] = $urandom_range(0, 2000);
          v[atd_pkg::REG_AXLE_BASE] = $urandom_range(1, 8191);
        end
      endcase
      write_regs(v);
      add_twist(0, 0);
      add_twist(32767, 1);
      add_twist(1, -32767);
      add_twist(-32768, 32767);
      add_twist(-32768, -1);
      add_random(260);
      wait_drained();
    end

    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
